@@ hw/rtl/lz4d_pkg.sv @@
// Shared types and constants of the LZ4 block decompressor.
`default_nettype none

package lz4d_pkg;

  // default sizes of the history window and of the byte counters
  localparam int WINDOW_BYTES_DEF = 65536;
  localparam int COUNT_BITS_DEF   = 30;

  // fixed field widths, register bit, queue depth and minimum match length
  localparam int SIZE_W    = 30;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int REG_BIT   = 2;
  localparam int Q_DEPTH   = 3;
  localparam int MATCH_MIN = 4;

  // register index, as seen on paddr[REG_BIT]
  localparam logic REG_EXPECTED_SIZE = 1'b0;

  // action codes
  localparam logic [1:0] ACT_BYTE = 2'd0;
  localparam logic [1:0] ACT_TICK = 2'd1;
  localparam logic [1:0] ACT_END  = 2'd2;

  // error codes
  localparam logic [2:0] ERR_OK          = 3'd0;
  localparam logic [2:0] ERR_TRUNC_LIT   = 3'd1;
  localparam logic [2:0] ERR_LIT_RANGE   = 3'd2;
  localparam logic [2:0] ERR_TRUNC_OFF   = 3'd3;
  localparam logic [2:0] ERR_BAD_OFF     = 3'd4;
  localparam logic [2:0] ERR_TRUNC_MATCH = 3'd5;
  localparam logic [2:0] ERR_MATCH_RANGE = 3'd6;
  localparam logic [2:0] ERR_SIZE        = 3'd7;

  // token and length-byte constants
  localparam logic [3:0] NIB_EXT  = 4'hf;
  localparam logic [7:0] BYTE_EXT = 8'hff;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic       accepted;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       copy_pending;
    logic       done_res;
    logic [2:0] error_code;
  } out_item_t;

  // parser to history stage control
  typedef struct packed {
    logic fire;
    logic wr_en;
    logic rd_en;
    logic from_hist;
  } hist_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/lz4d_ifs.sv @@
// Handshake interfaces of the source and result channels.
`default_nettype none

interface lz4d_in_if;
  import lz4d_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lz4d_out_if;
  import lz4d_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/lz4d_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lz4d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ hw/rtl/lz4d_parser.sv @@
// Sequence parser: token, lengths, literals, offset and match countdown.
`default_nettype none

module lz4d_parser #(
  parameter int WINDOW_BYTES = lz4d_pkg::WINDOW_BYTES_DEF,
  parameter int COUNT_BITS   = lz4d_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            fire,
  input  lz4d_pkg::in_item_t              item,
  input  logic [lz4d_pkg::SIZE_W-1:0]     expected_size,
  output lz4d_pkg::hist_ctl_t             ctl,
  output logic [$clog2(WINDOW_BYTES)-1:0] wr_addr,
  output logic [$clog2(WINDOW_BYTES)-1:0] rd_addr,
  output lz4d_pkg::out_item_t             res
);

  import lz4d_pkg::*;

  localparam int AW = $clog2(WINDOW_BYTES);
  localparam int CW = COUNT_BITS;
  localparam int MW = (CW > AW) ? CW : AW;
  localparam int SW = ((CW > SIZE_W) ? CW : SIZE_W) + 1;

  typedef enum logic [2:0] {
    PH_TOKEN,
    PH_LITEXT,
    PH_LITS,
    PH_OFFLO,
    PH_OFFHI,
    PH_MEXT,
    PH_COPY,
    PH_DONE
  } phase_t;

  phase_t        phase_r, phase_nxt;
  logic [3:0]    nibble_r, nibble_nxt;
  logic [CW-1:0] run_r, run_nxt;
  logic [15:0]   offset_r, offset_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [2:0]    err_r, err_nxt;
  logic [MW-1:0] count_wide;

  // saturating add of a byte to a counter
  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [7:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + (CW+1)'(b);
    sat_add = s[CW] ? '1 : s[CW-1:0];
  endfunction

  // run would carry the output beyond the expected size
  function automatic logic too_big(input logic [CW-1:0] oc, input logic [CW-1:0] run,
                                   input logic [SIZE_W-1:0] lim);
    logic [SW-1:0] t;
    t = SW'(oc) + SW'(run);
    too_big = t > SW'(lim);
  endfunction

  // next state and result of one item
  always_comb begin
    logic [CW-1:0] r;
    logic [CW-1:0] run_dec;
    logic [15:0]   o;
    r          = '0;
    o          = '0;
    run_dec    = run_r - CW'(1);
    phase_nxt  = phase_r;
    nibble_nxt = nibble_r;
    run_nxt    = run_r;
    offset_nxt = offset_r;
    count_nxt  = count_r;
    err_nxt    = err_r;
    res        = '0;
    ctl        = '0;
    ctl.fire   = fire;
    if (fire) begin
      case (item.action)
        ACT_BYTE: begin
          if (err_r != ERR_OK || phase_r == PH_DONE) begin
            res.accepted = 1'b1;
          end else if (phase_r != PH_COPY) begin
            res.accepted = 1'b1;
            case (phase_r)
              PH_TOKEN: begin
                nibble_nxt = item.in_byte[3:0];
                r          = CW'(item.in_byte[7:4]);
                run_nxt    = r;
                if (item.in_byte[7:4] == NIB_EXT) begin
                  phase_nxt = PH_LITEXT;
                end else if (too_big(count_r, r, expected_size)) begin
                  err_nxt = ERR_LIT_RANGE;
                end else begin
                  phase_nxt = (r != '0) ? PH_LITS : PH_OFFLO;
                end
              end
              PH_LITEXT: begin
                r       = sat_add(run_r, item.in_byte);
                run_nxt = r;
                if (item.in_byte != BYTE_EXT) begin
                  if (too_big(count_r, r, expected_size)) begin
                    err_nxt = ERR_LIT_RANGE;
                  end else begin
                    phase_nxt = (r != '0) ? PH_LITS : PH_OFFLO;
                  end
                end
              end
              PH_LITS: begin
                ctl.wr_en     = 1'b1;
                res.out_valid = 1'b1;
                res.out_byte  = item.in_byte;
                count_nxt     = sat_add(count_r, 8'd1);
                run_nxt       = run_dec;
                if (run_dec == '0) begin
                  phase_nxt = PH_OFFLO;
                end
              end
              PH_OFFLO: begin
                offset_nxt = {8'h00, item.in_byte};
                phase_nxt  = PH_OFFHI;
              end
              PH_OFFHI: begin
                o          = {item.in_byte, offset_r[7:0]};
                offset_nxt = o;
                if (o == '0 || CW'(o) > count_r) begin
                  err_nxt = ERR_BAD_OFF;
                end else if (nibble_r == NIB_EXT) begin
                  run_nxt   = CW'(nibble_r);
                  phase_nxt = PH_MEXT;
                end else begin
                  r       = CW'(nibble_r) + CW'(MATCH_MIN);
                  run_nxt = r;
                  if (too_big(count_r, r, expected_size)) begin
                    err_nxt = ERR_MATCH_RANGE;
                  end else begin
                    phase_nxt = PH_COPY;
                  end
                end
              end
              PH_MEXT: begin
                r = sat_add(run_r, item.in_byte);
                if (item.in_byte != BYTE_EXT) begin
                  r = sat_add(r, 8'(MATCH_MIN));
                  if (too_big(count_r, r, expected_size)) begin
                    err_nxt = ERR_MATCH_RANGE;
                  end else begin
                    phase_nxt = PH_COPY;
                  end
                end
                run_nxt = r;
              end
              default: begin
              end
            endcase
          end
        end
        ACT_TICK: begin
          // one match byte read back from the history
          if (err_r == ERR_OK && phase_r == PH_COPY) begin
            res.accepted  = 1'b1;
            res.out_valid = 1'b1;
            ctl.rd_en     = 1'b1;
            ctl.wr_en     = 1'b1;
            ctl.from_hist = 1'b1;
            count_nxt     = sat_add(count_r, 8'd1);
            run_nxt       = run_dec;
            if (run_dec == '0) begin
              phase_nxt = PH_TOKEN;
            end
          end
        end
        ACT_END: begin
          if (err_r != ERR_OK || phase_r != PH_COPY) begin
            res.accepted = 1'b1;
            res.done_res = 1'b1;
            if (err_r == ERR_OK) begin
              case (phase_r)
                PH_LITEXT: err_nxt = ERR_TRUNC_LIT;
                PH_LITS:   err_nxt = ERR_LIT_RANGE;
                PH_OFFHI:  err_nxt = ERR_TRUNC_OFF;
                PH_MEXT:   err_nxt = ERR_TRUNC_MATCH;
                PH_TOKEN, PH_OFFLO: begin
                  if (SW'(count_r) != SW'(expected_size)) begin
                    err_nxt = ERR_SIZE;
                  end
                end
                default: begin
                end
              endcase
            end
            phase_nxt = PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end
    res.copy_pending = (err_nxt == ERR_OK) && (phase_nxt == PH_COPY);
    res.error_code   = err_nxt;
  end

  // history addresses: write at the output count, read one offset behind
  assign count_wide = MW'(count_r);
  assign wr_addr    = count_wide[AW-1:0];
  assign rd_addr    = count_wide[AW-1:0] - AW'(offset_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_TOKEN;
      nibble_r <= '0;
      run_r    <= '0;
      offset_r <= '0;
      count_r  <= '0;
      err_r    <= ERR_OK;
    end else begin
      phase_r  <= phase_nxt;
      nibble_r <= nibble_nxt;
      run_r    <= run_nxt;
      offset_r <= offset_nxt;
      count_r  <= count_nxt;
      err_r    <= err_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/lz4d_hist.sv @@
// History stage: window RAM, delayed write and short-offset forwarding.
`default_nettype none

module lz4d_hist #(
  parameter int WINDOW_BYTES = lz4d_pkg::WINDOW_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  lz4d_pkg::hist_ctl_t             ctl,
  input  logic [$clog2(WINDOW_BYTES)-1:0] wr_addr,
  input  logic [$clog2(WINDOW_BYTES)-1:0] rd_addr,
  input  lz4d_pkg::out_item_t             res,
  output logic                            s1_valid,
  output lz4d_pkg::out_item_t             item
);

  import lz4d_pkg::*;

  localparam int AW = $clog2(WINDOW_BYTES);

  logic            valid_r;
  logic            we_r;
  logic            copy_r;
  logic            fwd_r;
  logic [7:0]      fwd_byte_r;
  logic [AW-1:0]   waddr_r;
  out_item_t       res_r;
  logic [7:0]      rd_data;
  logic [7:0]      s1_byte;

  // byte of the item in this stage: literal, RAM data or the byte just written
  assign s1_byte = copy_r ? (fwd_r ? fwd_byte_r : rd_data) : res_r.out_byte;

  always_comb begin
    item          = res_r;
    item.out_byte = s1_byte;
  end

  assign s1_valid = valid_r;

  // control of the write stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      we_r    <= 1'b0;
    end else begin
      valid_r <= ctl.fire;
      we_r    <= ctl.fire & ctl.wr_en;
    end
  end

  // payload; a read of the entry being written takes the byte in flight
  always_ff @(posedge clk) begin
    copy_r     <= ctl.from_hist;
    fwd_r      <= we_r && (waddr_r == rd_addr);
    fwd_byte_r <= s1_byte;
    waddr_r    <= wr_addr;
    res_r      <= res;
  end

  lz4d_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_BYTES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (we_r),
    .wr_addr (waddr_r),
    .wr_data (s1_byte),
    .rd_en   (ctl.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire

@@ hw/rtl/lz4d_outq.sv @@
// Small result queue between the history stage and the output channel.
`default_nettype none

module lz4d_outq (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  push,
  input  lz4d_pkg::out_item_t                   push_item,
  output logic [$clog2(lz4d_pkg::Q_DEPTH+1)-1:0] count,
  output logic                                  valid,
  output lz4d_pkg::out_item_t                   head,
  input  logic                                  ready
);

  import lz4d_pkg::*;

  localparam int PW = $clog2(Q_DEPTH);
  localparam int NW = $clog2(Q_DEPTH + 1);

  out_item_t     ent_r [Q_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] count_r, count_nxt;
  logic          pop;

  assign valid = count_r != '0;
  assign head  = ent_r[rd_ptr_r];
  assign count = count_r;
  assign pop   = valid & ready;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + NW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/lz4_block_decompressor_top.sv @@
// LZ4 block decompressor top level: register port, parser, history stage, result queue.
// A result is registered in the history stage and then in the result queue before it is offered.
// Throughput: one item per clock while the queue has room, source bytes and copy ticks alike;
// the history RAM takes one read and one write each cycle; a match offset of one is forwarded.
// Reset (rst_n low, synchronous) clears parser state, queue and expected_size; the history
// RAM is not cleared, as no legal offset reaches an entry not yet written in this block.
`default_nettype none

module lz4_block_decompressor_top #(
  parameter int WINDOW_BYTES = lz4d_pkg::WINDOW_BYTES_DEF,
  parameter int COUNT_BITS   = lz4d_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  lz4d_in_if.sink                       in_ch,
  lz4d_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lz4d_pkg::PADDR_W-1:0]  paddr,
  input  logic [lz4d_pkg::PDATA_W-1:0]  pwdata,
  output logic [lz4d_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  import lz4d_pkg::*;

  localparam int AW = $clog2(WINDOW_BYTES);
  localparam int NW = $clog2(Q_DEPTH + 1);

  logic [SIZE_W-1:0] expected_size_r;
  logic              fire;
  logic              in_ready;
  logic [NW:0]       occupancy;
  hist_ctl_t         ctl;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  out_item_t         res;
  logic              s1_valid;
  out_item_t         s1_item;
  logic [NW-1:0]     q_count;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr[REG_BIT] == REG_EXPECTED_SIZE) ? PDATA_W'(expected_size_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_size_r <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[REG_BIT] == REG_EXPECTED_SIZE) begin
      expected_size_r <= pwdata[SIZE_W-1:0];
    end
  end

  // take an item while the queue has room for it and the one in the history stage
  assign occupancy   = (NW+1)'(q_count) + (NW+1)'(s1_valid);
  assign in_ready    = occupancy < (NW+1)'(Q_DEPTH);
  assign in_ch.ready = in_ready;
  assign fire        = in_ch.valid & in_ready;

  lz4d_parser #(
    .WINDOW_BYTES (WINDOW_BYTES),
    .COUNT_BITS   (COUNT_BITS)
  ) u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .item          (in_ch.data),
    .expected_size (expected_size_r),
    .ctl           (ctl),
    .wr_addr       (wr_addr),
    .rd_addr       (rd_addr),
    .res           (res)
  );

  lz4d_hist #(
    .WINDOW_BYTES (WINDOW_BYTES)
  ) u_hist (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .wr_addr  (wr_addr),
    .rd_addr  (rd_addr),
    .res      (res),
    .s1_valid (s1_valid),
    .item     (s1_item)
  );

  lz4d_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_valid),
    .push_item (s1_item),
    .count     (q_count),
    .valid     (out_ch.valid),
    .head      (out_ch.data),
    .ready     (out_ch.ready)
  );

endmodule

`default_nettype wire

@@ hw/rtl/lz4d_checker.sv @@
// Port-level checks of the decompressor, bound to the top level.
`default_nettype none

module lz4d_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input lz4d_pkg::out_item_t out_data
);

  import lz4d_pkg::*;

  // queue is empty right after a reset edge
  a_reset_empty: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("result offered just after reset");

  // once an accepted item has passed the history stage into the queue, a result is offered
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("accepted item has no result two cycles later");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind lz4_block_decompressor_top lz4d_checker u_lz4d_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

`default_nettype wire
